/* rtl/act_pkg.sv */
// ----------------------------------------------------------------------------
// act_pkg
// Shared constants, codes and types of the alarm clock timekeeper.
// ----------------------------------------------------------------------------
package act_pkg;

   localparam int ALARM_SLOTS_DEF = 8;

   // field widths
   localparam int MODE_W = 2;
   localparam int KEY_W  = 2;
   localparam int HOUR_W = 5;
   localparam int MIN_W  = 6;
   localparam int SEC_W  = 6;
   localparam int SLOT_W = 3;
   localparam int SUB_W  = 16;
   localparam int INC_W  = 8;
   localparam int RING_W = 16;
   localparam int SNZ_W  = 8;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   localparam logic [CSR_AW-1:0] CSR_FRAC_INC   = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_FRAC_MOD   = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_FLASH_THR  = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_RING_SEC   = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_SNOOZE_SEC = 3'd4;

   localparam logic [INC_W-1:0]  FRAC_INC_RST   = 8'd12;
   localparam logic [SUB_W-1:0]  FRAC_MOD_RST   = 16'd16000;
   localparam logic [SUB_W-1:0]  FLASH_THR_RST  = 16'd4000;
   localparam logic [RING_W-1:0] RING_SEC_RST   = 16'd1800;
   localparam logic [SNZ_W-1:0]  SNOOZE_SEC_RST = 8'd255;

   // request modes
   localparam logic [MODE_W-1:0] MODE_TICK      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_KEY       = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SET_TIME  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SET_ALARM = 2'd3;

   // key codes
   localparam logic [KEY_W-1:0] KEY_NONE   = 2'd0;
   localparam logic [KEY_W-1:0] KEY_FIRST  = 2'd1;
   localparam logic [KEY_W-1:0] KEY_SECOND = 2'd2;

   // rollover limits, one bit wider than the counters
   localparam logic [SEC_W:0]  SEC_PER_MIN  = 7'd60;
   localparam logic [MIN_W:0]  MIN_PER_HOUR = 7'd60;
   localparam logic [HOUR_W:0] HOUR_PER_DAY = 6'd24;

   // one alarm slot as it moves between the control and the slot memory
   typedef struct packed {
      logic              vld;
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
   } act_slot_type;

endpackage

/* rtl/act_req_if.sv */
// ----------------------------------------------------------------------------
// act_req_if
// Request channel of the timekeeper: valid/ready plus one request.
// ----------------------------------------------------------------------------
interface act_req_if
   import act_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [KEY_W-1:0]  key_code;
   logic [HOUR_W-1:0] set_hour;
   logic [MIN_W-1:0]  set_minute;
   logic [SLOT_W-1:0] slot_index;
   logic              slot_enable;

   modport source (
      output valid, mode, key_code, set_hour, set_minute, slot_index, slot_enable,
      input  ready
   );

   modport sink (
      input  valid, mode, key_code, set_hour, set_minute, slot_index, slot_enable,
      output ready
   );
endinterface

/* rtl/act_rsp_if.sv */
// ----------------------------------------------------------------------------
// act_rsp_if
// Response channel of the timekeeper: valid/ready plus one result.
// ----------------------------------------------------------------------------
interface act_rsp_if
   import act_pkg::*;
;
   logic              valid;
   logic              ready;
   logic              speaker_level;
   logic              flash_phase;
   logic [HOUR_W-1:0] now_hour;
   logic [MIN_W-1:0]  now_minute;
   logic [SEC_W-1:0]  now_second;
   logic              minute_changed;
   logic              ringing;
   logic [KEY_W-1:0]  key_passed;

   modport source (
      output valid, speaker_level, flash_phase, now_hour, now_minute, now_second,
             minute_changed, ringing, key_passed,
      input  ready
   );

   modport sink (
      input  valid, speaker_level, flash_phase, now_hour, now_minute, now_second,
             minute_changed, ringing, key_passed,
      output ready
   );
endinterface

/* rtl/act_alarm_ram.sv */
// ----------------------------------------------------------------------------
// act_alarm_ram
// Alarm slot memory: one write port, one read port with registered data.
// Valid bits sit in flops so reset empties every slot at once.
// ----------------------------------------------------------------------------
module act_alarm_ram
   import act_pkg::*;
#(
   parameter int ALARM_SLOTS = ALARM_SLOTS_DEF,
   parameter int SLOT_AW     = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [SLOT_AW-1:0] wr_addr,
   input  act_slot_type       wr_data,
   input  logic               rd_en,
   input  logic [SLOT_AW-1:0] rd_addr,
   output act_slot_type       rd_data
);

   logic [HOUR_W+MIN_W-1:0] mem [ALARM_SLOTS];
   logic [ALARM_SLOTS-1:0]  valid_ff;
   logic [ALARM_SLOTS-1:0]  valid_in;
   act_slot_type            rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = wr_data.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_data.hour, wr_data.minute};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff.vld                  <= valid_ff[rd_addr];
         {rd_data_ff.hour, rd_data_ff.minute} <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/alarm_clock_timekeeper_core.sv */
// ----------------------------------------------------------------------------
// alarm_clock_timekeeper_core
// Real-time clock with sub-second accumulator, alarm slots and snooze.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per handshake: a tick, a key press, a time set
//   or an alarm slot write. rsp_ch returns exactly one result per request: the
//   time, flash phase, speaker level, ringing flag and any key passed on.
//   csr_we/csr_addr/csr_wdata write the five configuration registers; write
//   them only while no request is in flight.
// Sequencing:
//   State is updated at the accepting edge; the result register is loaded
//   from the finish state once the output register is free, and no new
//   request is taken before that. A new-minute tick also sweeps the alarm
//   slot memory, one slot per cycle through its single read port.
// Reset:
//   Time, snooze and ring counters clear, configuration returns to defaults
//   and every alarm slot becomes invalid, all at the same clock edge.
// Stall:
//   A new request is taken while an earlier result waits in the output
//   register; its result is held back until the receiver takes the first.
// ----------------------------------------------------------------------------
module alarm_clock_timekeeper_core
   import act_pkg::*;
#(
   parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   act_req_if.sink           req_ch,
   act_rsp_if.source         rsp_ch,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int SLOT_AW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
   localparam int CNT_W   = $clog2(ALARM_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } act_state_type;

   act_state_type state_ff, state_in;

   // configuration
   logic [INC_W-1:0]  frac_inc_ff,   frac_inc_in;
   logic [SUB_W-1:0]  frac_mod_ff,   frac_mod_in;
   logic [SUB_W-1:0]  flash_thr_ff,  flash_thr_in;
   logic [RING_W-1:0] ring_sec_ff,   ring_sec_in;
   logic [SNZ_W-1:0]  snooze_sec_ff, snooze_sec_in;

   // time state
   logic [SUB_W-1:0]  sub_ff,    sub_in;
   logic [SEC_W-1:0]  sec_ff,    sec_in;
   logic [MIN_W-1:0]  min_ff,    min_in;
   logic [HOUR_W-1:0] hour_ff,   hour_in;
   logic              flash_ff,  flash_in;
   logic [SNZ_W-1:0]  snooze_ff, snooze_in;
   logic [RING_W-1:0] ring_ff,   ring_in;

   // per-request flags held until the result is loaded
   logic              mc_ff, mc_in;
   logic [KEY_W-1:0]  kp_ff, kp_in;

   // alarm sweep
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic              cmp_vld_ff,  cmp_vld_in;

   // result register
   logic              rsp_vld_ff, rsp_vld_in;
   logic              spk_ff, spk_in;
   logic              ph_ff, ph_in;
   logic [HOUR_W-1:0] o_hour_ff, o_hour_in;
   logic [MIN_W-1:0]  o_min_ff, o_min_in;
   logic [SEC_W-1:0]  o_sec_ff, o_sec_in;
   logic              o_mc_ff, o_mc_in;
   logic              o_ring_ff, o_ring_in;
   logic [KEY_W-1:0]  o_kp_ff, o_kp_in;

   // memory ports
   logic               wr_en;
   logic [SLOT_AW-1:0] wr_addr;
   act_slot_type       wr_data;
   logic               rd_en;
   logic [SLOT_AW-1:0] rd_addr;
   act_slot_type       rd_data;

   logic                req_fire;
   logic                out_free;
   logic                scan_more;
   logic [SUB_W:0]      sum;
   logic [SUB_W+1:0]    diff;
   logic [SEC_W-1:0]    sec_inc;
   logic [MIN_W:0]      min_inc;
   logic [HOUR_W:0]     hour_inc;
   logic [5:0]          slot_ext;
   logic                new_min;
   logic                ringing_now;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_vld_ff || rsp_ch.ready;
   assign scan_more = scan_cnt_ff < CNT_W'(ALARM_SLOTS);

   assign req_ch.ready = (state_ff == ST_IDLE);

   // config writes
   always_comb begin
      frac_inc_in   = frac_inc_ff;
      frac_mod_in   = frac_mod_ff;
      flash_thr_in  = flash_thr_ff;
      ring_sec_in   = ring_sec_ff;
      snooze_sec_in = snooze_sec_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_FRAC_INC:   frac_inc_in   = csr_wdata[INC_W-1:0];
            CSR_FRAC_MOD:   frac_mod_in   = csr_wdata[SUB_W-1:0];
            CSR_FLASH_THR:  flash_thr_in  = csr_wdata[SUB_W-1:0];
            CSR_RING_SEC:   ring_sec_in   = csr_wdata[RING_W-1:0];
            CSR_SNOOZE_SEC: snooze_sec_in = csr_wdata[SNZ_W-1:0];
            default: ;
         endcase
      end
   end

   // memory write from an alarm slot request
   assign slot_ext     = {3'b000, req_ch.slot_index};
   assign wr_en        = req_fire && (req_ch.mode == MODE_SET_ALARM)
                         && (slot_ext < 6'(ALARM_SLOTS));
   assign wr_addr      = slot_ext[SLOT_AW-1:0];
   assign wr_data      = {req_ch.slot_enable, req_ch.set_hour, req_ch.set_minute};

   assign rd_en   = (state_ff == ST_SCAN) && scan_more;
   assign rd_addr = scan_cnt_ff[SLOT_AW-1:0];

   act_alarm_ram #(
      .ALARM_SLOTS (ALARM_SLOTS),
      .SLOT_AW     (SLOT_AW)
   ) u_alarm_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // request processing and sequencing
   always_comb begin
      state_in    = state_ff;
      sub_in      = sub_ff;
      sec_in      = sec_ff;
      min_in      = min_ff;
      hour_in     = hour_ff;
      flash_in    = flash_ff;
      snooze_in   = snooze_ff;
      ring_in     = ring_ff;
      mc_in       = mc_ff;
      kp_in       = kp_ff;
      scan_cnt_in = scan_cnt_ff;
      cmp_vld_in  = 1'b0;
      new_min     = 1'b0;

      sum      = {1'b0, sub_ff} + {{(SUB_W-INC_W+1){1'b0}}, frac_inc_ff};
      diff     = {1'b0, sum} - {2'b00, frac_mod_ff};
      sec_inc  = sec_ff + 6'd1;
      min_inc  = {1'b0, min_ff} + 7'd1;
      hour_inc = {1'b0, hour_ff} + 6'd1;

      ringing_now = (snooze_ff == '0) && (ring_ff != '0);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kp_in = KEY_NONE;
               case (req_ch.mode)
                  MODE_TICK: begin
                     if (!diff[SUB_W+1]) begin
                        // one second completes
                        flash_in = 1'b0;
                        sub_in   = diff[SUB_W-1:0];
                        sec_in   = sec_inc;
                        if (snooze_ff != '0) begin
                           snooze_in = snooze_ff - 1'b1;
                           ring_in   = ring_sec_ff;
                        end else if (ring_ff != '0) begin
                           ring_in = ring_ff - 1'b1;
                        end
                        if ({1'b0, sec_inc} >= SEC_PER_MIN) begin
                           new_min = 1'b1;
                           sec_in  = '0;
                           if (min_inc >= MIN_PER_HOUR) begin
                              min_in  = '0;
                              hour_in = (hour_inc >= HOUR_PER_DAY) ? '0
                                                                   : hour_inc[HOUR_W-1:0];
                           end else begin
                              min_in = min_inc[MIN_W-1:0];
                           end
                        end
                     end else begin
                        sub_in = sum[SUB_W-1:0];
                        if (sum[SUB_W-1:0] > flash_thr_ff) begin
                           flash_in = 1'b1;
                        end
                     end
                  end
                  MODE_KEY: begin
                     if (req_ch.key_code == KEY_FIRST || req_ch.key_code == KEY_SECOND) begin
                        if (snooze_ff != '0) begin
                           snooze_in = '0;
                           ring_in   = '0;
                        end else if (ring_ff != '0) begin
                           snooze_in = snooze_sec_ff;
                        end else begin
                           kp_in = req_ch.key_code;
                        end
                     end
                  end
                  MODE_SET_TIME: begin
                     sub_in  = '0;
                     sec_in  = '0;
                     hour_in = req_ch.set_hour;
                     min_in  = req_ch.set_minute;
                  end
                  MODE_SET_ALARM: ;   // handled by the memory write port
                  default: ;
               endcase
               mc_in       = new_min;
               scan_cnt_in = '0;
               state_in    = new_min ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            // read of slot n issues while slot n-1 data is compared
            if (scan_more) begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
               cmp_vld_in  = 1'b1;
            end
            if (cmp_vld_ff && rd_data.vld && rd_data.hour == hour_ff
                && rd_data.minute == min_ff) begin
               ring_in = ring_sec_ff;
            end
            if (!scan_more && !cmp_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      spk_in     = spk_ff;
      ph_in      = ph_ff;
      o_hour_in  = o_hour_ff;
      o_min_in   = o_min_ff;
      o_sec_in   = o_sec_ff;
      o_mc_in    = o_mc_ff;
      o_ring_in  = o_ring_ff;
      o_kp_in    = o_kp_ff;
      if (rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_vld_in = 1'b1;
         spk_in     = ringing_now ? flash_ff : 1'b1;
         ph_in      = flash_ff;
         o_hour_in  = hour_ff;
         o_min_in   = min_ff;
         o_sec_in   = sec_ff;
         o_mc_in    = mc_ff;
         o_ring_in  = ringing_now;
         o_kp_in    = kp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         frac_inc_ff   <= FRAC_INC_RST;
         frac_mod_ff   <= FRAC_MOD_RST;
         flash_thr_ff  <= FLASH_THR_RST;
         ring_sec_ff   <= RING_SEC_RST;
         snooze_sec_ff <= SNOOZE_SEC_RST;
         sub_ff        <= '0;
         sec_ff        <= '0;
         min_ff        <= '0;
         hour_ff       <= '0;
         flash_ff      <= 1'b0;
         snooze_ff     <= '0;
         ring_ff       <= '0;
         scan_cnt_ff   <= '0;
         cmp_vld_ff    <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frac_inc_ff   <= frac_inc_in;
         frac_mod_ff   <= frac_mod_in;
         flash_thr_ff  <= flash_thr_in;
         ring_sec_ff   <= ring_sec_in;
         snooze_sec_ff <= snooze_sec_in;
         sub_ff        <= sub_in;
         sec_ff        <= sec_in;
         min_ff        <= min_in;
         hour_ff       <= hour_in;
         flash_ff      <= flash_in;
         snooze_ff     <= snooze_in;
         ring_ff       <= ring_in;
         scan_cnt_ff   <= scan_cnt_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mc_ff     <= mc_in;
      kp_ff     <= kp_in;
      spk_ff    <= spk_in;
      ph_ff     <= ph_in;
      o_hour_ff <= o_hour_in;
      o_min_ff  <= o_min_in;
      o_sec_ff  <= o_sec_in;
      o_mc_ff   <= o_mc_in;
      o_ring_ff <= o_ring_in;
      o_kp_ff   <= o_kp_in;
   end

   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.speaker_level  = spk_ff;
   assign rsp_ch.flash_phase    = ph_ff;
   assign rsp_ch.now_hour       = o_hour_ff;
   assign rsp_ch.now_minute     = o_min_ff;
   assign rsp_ch.now_second     = o_sec_ff;
   assign rsp_ch.minute_changed = o_mc_ff;
   assign rsp_ch.ringing        = o_ring_ff;
   assign rsp_ch.key_passed     = o_kp_ff;

   // only a tick can start the alarm sweep
   a_scan_only_tick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.mode != MODE_TICK) |=> (state_ff == ST_FINISH))
      else $error("non-tick request entered alarm sweep");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_cnt_ff <= CNT_W'(ALARM_SLOTS))
      else $error("alarm sweep counter past last slot");

   a_minute_at_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && o_mc_ff) |-> (o_sec_ff == '0))
      else $error("minute rollover reported with nonzero seconds");

   a_ring_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !o_ring_ff) |-> spk_ff)
      else $error("speaker driven low while not ringing");

endmodule

/* tb/sv/alarm_clock_timekeeper_core_tb.sv */
// ----------------------------------------------------------------------------
// alarm_clock_timekeeper_core_tb
// Self-checking bench for the alarm clock timekeeper core.
// Drives ticks, key presses, time sets and alarm slot writes through the
// request channel under several clock settings. Every response is checked
// against an in-bench copy of the clock state. Both channels stall at random,
// and one long output stall backs the core up.
// ----------------------------------------------------------------------------
module alarm_clock_timekeeper_core_tb;
   import act_pkg::*;

   localparam int                CYCLE_LIMIT = 600000;
   localparam int                GAP_MAX     = 13;
   localparam int                SETTLE      = ALARM_SLOTS_DEF + 8;
   localparam logic [KEY_W-1:0]  KEY_UNUSED  = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key_code;
      logic [HOUR_W-1:0] set_hour;
      logic [MIN_W-1:0]  set_minute;
      logic [SLOT_W-1:0] slot_index;
      logic              slot_enable;
   } clock_request_type;

   typedef struct packed {
      logic              speaker_level;
      logic              flash_phase;
      logic [HOUR_W-1:0] now_hour;
      logic [MIN_W-1:0]  now_minute;
      logic [SEC_W-1:0]  now_second;
      logic              minute_changed;
      logic              ringing;
      logic [KEY_W-1:0]  key_passed;
   } clock_status_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [CSR_AW-1:0] csr_addr;
   logic [CSR_DW-1:0] csr_wdata;

   act_req_if req_if ();
   act_rsp_if rsp_if ();

   alarm_clock_timekeeper_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // clock state mirror
   logic [INC_W-1:0]  frac_inc   = FRAC_INC_RST;
   logic [SUB_W-1:0]  frac_mod   = FRAC_MOD_RST;
   logic [SUB_W-1:0]  flash_thr  = FLASH_THR_RST;
   logic [RING_W-1:0] ring_len   = RING_SEC_RST;
   logic [SNZ_W-1:0]  snooze_len = SNOOZE_SEC_RST;

   logic [SUB_W-1:0]  sub_second  = '0;
   logic [SEC_W-1:0]  sec_count   = '0;
   logic [MIN_W-1:0]  min_count   = '0;
   logic [HOUR_W-1:0] hour_count  = '0;
   logic              flash_on    = 1'b0;
   logic [SNZ_W-1:0]  snooze_left = '0;
   logic [RING_W-1:0] ring_left   = '0;
   act_slot_type      alarm_slots [ALARM_SLOTS_DEF];

   clock_status_type status_queue[$];

   int cycle_count       = 0;
   int fail_count        = 0;
   int accepted_requests = 0;
   int settings_used     = 0;
   int minute_rollovers  = 0;
   int alarm_matches     = 0;
   int snoozes           = 0;
   int rsp_hold          = 0;
   bit req_idle          = 1'b1;
   bit rsp_idle          = 1'b1;

   initial begin
      foreach (alarm_slots[k])
         alarm_slots[k] = '0;
   end

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic clock_status_type predict_status(input clock_request_type r);
      clock_status_type s;
      logic [SUB_W:0] sum;
      int mins;
      int hrs;
      bit ring_now;
      s = '0;
      case (r.mode)
         MODE_TICK: begin
            sum = {1'b0, sub_second} + {{(SUB_W-INC_W+1){1'b0}}, frac_inc};
            if (sum >= {1'b0, frac_mod}) begin
               flash_on   = 1'b0;
               sub_second = sum[SUB_W-1:0] - frac_mod;
               sec_count  = sec_count + 1'b1;
               if (snooze_left != 0) begin
                  snooze_left = snooze_left - 1'b1;
                  ring_left   = ring_len;
               end else if (ring_left != 0) begin
                  ring_left = ring_left - 1'b1;
               end
               if (sec_count >= 60) begin
                  s.minute_changed = 1'b1;
                  minute_rollovers++;
                  sec_count = '0;
                  // counters set out of range wrap on their next advance
                  mins = min_count + 1;
                  if (mins >= 60) begin
                     mins = 0;
                     hrs  = hour_count + 1;
                     if (hrs >= 24)
                        hrs = 0;
                     hour_count = hrs[HOUR_W-1:0];
                  end
                  min_count = mins[MIN_W-1:0];
                  foreach (alarm_slots[k]) begin
                     if (alarm_slots[k].vld && alarm_slots[k].hour == hour_count &&
                         alarm_slots[k].minute == min_count) begin
                        ring_left = ring_len;
                        alarm_matches++;
                     end
                  end
               end
            end else begin
               sub_second = sum[SUB_W-1:0];
               if (sub_second > flash_thr)
                  flash_on = 1'b1;
            end
         end
         MODE_KEY: begin
            if (r.key_code == KEY_FIRST || r.key_code == KEY_SECOND) begin
               if (snooze_left != 0) begin
                  snooze_left = '0;
                  ring_left   = '0;
               end else if (ring_left != 0) begin
                  snooze_left = snooze_len;
                  snoozes++;
               end else begin
                  s.key_passed = r.key_code;
               end
            end
         end
         MODE_SET_TIME: begin
            sub_second = '0;
            sec_count  = '0;
            hour_count = r.set_hour;
            min_count  = r.set_minute;
         end
         default: begin
            if (r.slot_index < ALARM_SLOTS_DEF)
               alarm_slots[r.slot_index] = '{vld: r.slot_enable, hour: r.set_hour,
                                             minute: r.set_minute};
         end
      endcase
      ring_now        = (snooze_left == 0) && (ring_left != 0);
      s.ringing       = ring_now;
      s.speaker_level = ring_now ? flash_on : 1'b1;
      s.flash_phase   = flash_on;
      s.now_hour      = hour_count;
      s.now_minute    = min_count;
      s.now_second    = sec_count;
      return s;
   endfunction

   function automatic clock_request_type make_request(input logic [MODE_W-1:0] mode,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [HOUR_W-1:0] hr,
                                                      input logic [MIN_W-1:0] mn,
                                                      input logic [SLOT_W-1:0] slot,
                                                      input logic en);
      clock_request_type r;
      r = '{mode: mode, key_code: key, set_hour: hr, set_minute: mn,
            slot_index: slot, slot_enable: en};
      return r;
   endfunction

   function automatic clock_request_type random_request();
      clock_request_type r;
      int pick;
      r = make_request(MODE_TICK, KEY_W'($urandom_range(0, 3)), HOUR_W'($urandom_range(0, 31)),
                       MIN_W'($urandom_range(0, 63)), SLOT_W'($urandom_range(0, 7)),
                       1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 99);
      if (pick < 15)
         r.mode = MODE_KEY;
      else if (pick < 22)
         r.mode = MODE_SET_TIME;
      else if (pick < 35)
         r.mode = MODE_SET_ALARM;
      return r;
   endfunction

   task automatic send_request(input clock_request_type r);
      int gap;
      gap = req_idle ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.mode        <= r.mode;
      req_if.key_code    <= r.key_code;
      req_if.set_hour    <= r.set_hour;
      req_if.set_minute  <= r.set_minute;
      req_if.slot_index  <= r.slot_index;
      req_if.slot_enable <= r.slot_enable;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      status_queue.push_back(predict_status(r));
      accepted_requests++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FRAC_INC:   frac_inc   = value[INC_W-1:0];
         CSR_FRAC_MOD:   frac_mod   = value;
         CSR_FLASH_THR:  flash_thr  = value;
         CSR_RING_SEC:   ring_len   = value;
         CSR_SNOOZE_SEC: snooze_len = value[SNZ_W-1:0];
         default: ;
      endcase
   endtask

   // Alarm set one minute ahead, then ticks toward the minute rollover, at most
   // 240 plus 20 more, with key presses mixed in to snooze and cancel.
   task automatic alarm_sequence();
      clock_request_type r;
      logic [HOUR_W-1:0] hr;
      logic [MIN_W-1:0] mn;
      int per_second;
      int ticks;
      hr = HOUR_W'($urandom_range(0, 23));
      mn = MIN_W'($urandom_range(0, 59));
      send_request(make_request(MODE_SET_ALARM, KEY_NONE, hr, mn,
                                SLOT_W'($urandom_range(0, 7)),
                                $urandom_range(0, 7) != 0));
      r = make_request(MODE_SET_TIME, KEY_NONE, hr, mn - 1'b1, '0, 1'b0);
      if (mn == 0) begin
         r.set_minute = 6'd59;
         r.set_hour   = (hr == 0) ? 5'd23 : hr - 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
         r.set_hour   = HOUR_W'($urandom_range(0, 31));
         r.set_minute = MIN_W'($urandom_range(60, 63));
      end
      send_request(r);
      per_second = (int'(frac_mod) + int'(frac_inc) - 1) / int'(frac_inc);
      ticks = 61 * per_second + $urandom_range(0, 30);
      if (ticks > 240)
         ticks = 240;
      for (int i = 0; i < ticks + 20; i++) begin
         r = make_request(MODE_TICK, KEY_W'($urandom_range(0, 3)),
                          HOUR_W'($urandom_range(0, 31)), MIN_W'($urandom_range(0, 63)),
                          SLOT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
         if ($urandom_range(0, 99) < ((i < ticks) ? 6 : 25))
            r.mode = MODE_KEY;
         send_request(r);
      end
   endtask

   task automatic run_phase(input logic [INC_W-1:0] inc, input logic [SUB_W-1:0] modulus,
                            input logic [SUB_W-1:0] thr, input logic [RING_W-1:0] ring,
                            input logic [SNZ_W-1:0] snz, input int target,
                            input int sequence_pct, input int hold_cycles);
      int start;
      drain_results();
      write_csr(CSR_FRAC_INC, CSR_DW'(inc));
      write_csr(CSR_FRAC_MOD, modulus);
      write_csr(CSR_FLASH_THR, thr);
      write_csr(CSR_RING_SEC, ring);
      write_csr(CSR_SNOOZE_SEC, CSR_DW'(snz));
      settings_used++;
      start = accepted_requests;
      if (hold_cycles > 0) begin
         // receiver sits out while requests keep coming
         req_idle = 1'b0;
         rsp_hold = hold_cycles;
         repeat (30) send_request(random_request());
      end
      while (accepted_requests - start < target) begin
         req_idle = $urandom_range(0, 3) != 0;
         rsp_idle = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 99) < sequence_pct)
            alarm_sequence();
         else
            repeat (10) send_request(random_request());
      end
   endtask

   task automatic test_power_on();
      repeat (3) send_request(make_request(MODE_TICK, KEY_NONE, '0, '0, '0, 1'b0));
      send_request(make_request(MODE_KEY, KEY_FIRST, '0, '0, '0, 1'b0));
      send_request(make_request(MODE_KEY, KEY_SECOND, '0, '0, '0, 1'b0));
   endtask

   task automatic test_field_extremes();
      send_request(make_request(MODE_SET_TIME, KEY_NONE, 5'd23, 6'd59, '0, 1'b0));
      send_request(make_request(MODE_SET_TIME, KEY_UNUSED, 5'd31, 6'd63, 3'd7, 1'b1));
      send_request(make_request(MODE_SET_TIME, KEY_NONE, '0, '0, '0, 1'b0));
      send_request(make_request(MODE_SET_ALARM, KEY_NONE, 5'd31, 6'd63, 3'd0, 1'b1));
      send_request(make_request(MODE_SET_ALARM, KEY_NONE, '0, '0, 3'd7, 1'b0));
      send_request(make_request(MODE_SET_ALARM, KEY_UNUSED, 5'd23, 6'd59, 3'd7, 1'b1));
      send_request(make_request(MODE_KEY, KEY_UNUSED, 5'd31, 6'd63, 3'd7, 1'b1));
      send_request(make_request(MODE_KEY, KEY_NONE, '0, '0, '0, 1'b0));
      send_request(make_request(MODE_TICK, KEY_UNUSED, 5'd31, 6'd63, 3'd7, 1'b1));
      drain_results();
      write_csr(CSR_FRAC_INC, CSR_DW'(8'd255));
      write_csr(CSR_FRAC_MOD, 16'd65280);
      write_csr(CSR_FLASH_THR, 16'd0);
      write_csr(CSR_RING_SEC, 16'd65535);
      write_csr(CSR_SNOOZE_SEC, 16'd0);
      settings_used++;
      repeat (3) send_request(make_request(MODE_TICK, KEY_NONE, '0, '0, '0, 1'b0));
      send_request(make_request(MODE_SET_TIME, KEY_NONE, 5'd31, 6'd63, '0, 1'b0));
      send_request(make_request(MODE_TICK, KEY_NONE, '0, '0, '0, 1'b0));
   endtask

   task automatic test_alarm_and_snooze();
      run_phase(8'd1, 16'd1, 16'd0, 16'd40, 8'd10, 160, 60, 0);
      // zero snooze length: a snooze key leaves the alarm ringing
      run_phase(8'd100, 16'd250, 16'd120, 16'd25, 8'd0, 190, 55, 0);
   endtask

   task automatic test_accumulator_wrap();
      // modulus below the increment: accumulator climbs and wraps past 16 bits
      run_phase(8'd255, 16'd1, 16'd0, 16'd65535, 8'd255, 160, 40, 0);
      run_phase(8'd255, 16'd65280, 16'd65535, 16'd0, 8'd1, 100, 10, 0);
      // modulus lowered under a high accumulator: catch-up seconds
      run_phase(8'd200, 16'd5000, 16'd2500, 16'd12, 8'd4, 160, 50, 0);
   endtask

   task automatic test_output_backpressure();
      run_phase(8'd255, 16'd255, 16'd128, 16'd30, 8'd255, 160, 50, 400);
   endtask

   task automatic test_random_settings();
      logic [INC_W-1:0] inc;
      for (int n = 0; n < 2; n++) begin
         inc = INC_W'($urandom_range(1, 255));
         run_phase(inc, SUB_W'($urandom_range(1, 3 * int'(inc))),
                   SUB_W'($urandom_range(0, 3 * int'(inc))),
                   RING_W'($urandom_range(0, 90)), SNZ_W'($urandom_range(0, 20)), 120, 50, 0);
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial begin : result_checker
      int stall;
      clock_status_type want;
      clock_status_type got;
      stall = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got = '{speaker_level: rsp_if.speaker_level, flash_phase: rsp_if.flash_phase,
                    now_hour: rsp_if.now_hour, now_minute: rsp_if.now_minute,
                    now_second: rsp_if.now_second, minute_changed: rsp_if.minute_changed,
                    ringing: rsp_if.ringing, key_passed: rsp_if.key_passed};
            if (status_queue.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = status_queue.pop_front();
               compare_field("speaker_level", 16'(want.speaker_level),
                             16'(got.speaker_level));
               compare_field("flash_phase", 16'(want.flash_phase), 16'(got.flash_phase));
               compare_field("now_hour", 16'(want.now_hour), 16'(got.now_hour));
               compare_field("now_minute", 16'(want.now_minute), 16'(got.now_minute));
               compare_field("now_second", 16'(want.now_second), 16'(got.now_second));
               compare_field("minute_changed", 16'(want.minute_changed),
                             16'(got.minute_changed));
               compare_field("ringing", 16'(want.ringing), 16'(got.ringing));
               compare_field("key_passed", 16'(want.key_passed), 16'(got.key_passed));
            end
            stall = rsp_idle ? $urandom_range(0, GAP_MAX) : 0;
         end
         if (rsp_hold > 0) begin
            stall    = rsp_hold;
            rsp_hold = 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_addr           <= '0;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.mode        <= MODE_TICK;
      req_if.key_code    <= KEY_NONE;
      req_if.set_hour    <= '0;
      req_if.set_minute  <= '0;
      req_if.slot_index  <= '0;
      req_if.slot_enable <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_power_on();
      test_field_extremes();
      test_alarm_and_snooze();
      test_accumulator_wrap();
      test_output_backpressure();
      test_random_settings();
      drain_results();

      $display("%0d requests checked under %0d register settings", accepted_requests,
               settings_used);
      $display("%0d minute rollovers, %0d alarm matches, %0d snoozes", minute_rollovers,
               alarm_matches, snoozes);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
